// ===== design/etok_pkg.sv =====
// Expression tokenizer package: token kinds, run modes, byte classes,
// the token record and the small lookup functions used by etok_step.
// No dependencies.
package etok_pkg;

  localparam int unsigned CharBits  = 8;
  localparam int unsigned FieldBits = 16;
  localparam int unsigned ClipBits  = 32;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrBits   = 2;
  localparam int unsigned CntBits   = 3;
  localparam int unsigned KwLen     = 4;

  typedef enum logic [3:0] {
    KIND_EOI     = 4'd0,
    KIND_UNKNOWN = 4'd1,
    KIND_IDENT   = 4'd2,
    KIND_NUMBER  = 4'd3,
    KIND_PLUS    = 4'd4,
    KIND_MINUS   = 4'd5,
    KIND_STAR    = 4'd6,
    KIND_SLASH   = 4'd7,
    KIND_LPAREN  = 4'd8,
    KIND_RPAREN  = 4'd9,
    KIND_COLON   = 4'd10,
    KIND_COMMA   = 4'd11,
    KIND_KEYWORD = 4'd12
  } token_kind_e;

  // pending run, one-hot
  typedef enum logic [2:0] {
    MODE_NONE    = 3'b001,
    MODE_LETTERS = 3'b010,
    MODE_DIGITS  = 3'b100
  } run_mode_e;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_LETTER,
    CLS_DIGIT,
    CLS_SPACE,
    CLS_SINGLE
  } char_class_e;

  typedef struct packed {
    token_kind_e           kind;
    logic [FieldBits-1:0]  start;
    logic [FieldBits-1:0]  length;
    logic                  last;
  } token_t;

  // up to two tokens written into the result queue in one cycle
  typedef struct packed {
    logic   push0;
    logic   push1;
    token_t tok0;
    token_t tok1;
  } push_t;

  function automatic char_class_e classify(input logic [CharBits-1:0] c);
    char_class_e cls;
    if (c == 8'h00) begin
      cls = CLS_END;
    end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
      cls = CLS_LETTER;
    end else if (c >= "0" && c <= "9") begin
      cls = CLS_DIGIT;
    end else if (c == " " || (c >= 8'h09 && c <= 8'h0D)) begin
      cls = CLS_SPACE;
    end else begin
      cls = CLS_SINGLE;
    end
    return cls;
  endfunction

  function automatic token_kind_e single_kind(input logic [CharBits-1:0] c);
    token_kind_e k;
    case (c)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      ":":     k = KIND_COLON;
      ",":     k = KIND_COMMA;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // the keyword "with", one byte per position
  function automatic logic [CharBits-1:0] kw_char(input logic [1:0] idx);
    logic [CharBits-1:0] c;
    unique case (idx)
      2'd0:    c = "w";
      2'd1:    c = "i";
      2'd2:    c = "t";
      default: c = "h";
    endcase
    return c;
  endfunction

  function automatic logic [FieldBits-1:0] clip16(input logic [ClipBits-1:0] v);
    logic [FieldBits-1:0] r;
    if (v[ClipBits-1:FieldBits] != '0) begin
      r = '1;
    end else begin
      r = v[FieldBits-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/etok_if.sv =====
// Valid/ready channel interfaces for the expression tokenizer:
// one for input bytes, one for tokens. No dependencies.
interface etok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface etok_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface

// ===== design/etok_step.sv =====
// Input byte register, run state and the per-byte token logic.
// Depends on etok_pkg.
module etok_step #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [etok_pkg::CharBits-1:0] char_i,
  input  logic                          room_i,
  output etok_pkg::push_t               push_o
);

  logic                          valid_q;
  logic [etok_pkg::CharBits-1:0] byte_q;
  etok_pkg::run_mode_e           mode_q, mode_d;
  logic [OFFSET_BITS-1:0]        off_q, off_d, start_q, start_d, off_adv;
  logic [2:0]                    kp_q, kp_d, base_kp;
  logic                          kf_q, kf_d, base_kf, kw_match;
  logic                          fire, has_run, do_flush, do_own;
  etok_pkg::char_class_e         cls;
  etok_pkg::token_t              run_tok, own_tok;
  etok_pkg::token_kind_e         run_kind;

  // byte moves on when the result queue can take two tokens
  assign fire       = valid_q && room_i;
  assign in_ready_o = !valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= char_i;
    end
  end

  // classification and the two candidate tokens
  always_comb begin
    cls     = etok_pkg::classify(byte_q);
    has_run = (mode_q != etok_pkg::MODE_NONE);
    if (mode_q == etok_pkg::MODE_DIGITS) begin
      run_kind = etok_pkg::KIND_NUMBER;
    end else if (!kf_q && kp_q == 3'(etok_pkg::KwLen)) begin
      run_kind = etok_pkg::KIND_KEYWORD;
    end else begin
      run_kind = etok_pkg::KIND_IDENT;
    end
    run_tok.kind   = run_kind;
    run_tok.start  = etok_pkg::clip16(etok_pkg::ClipBits'(start_q));
    run_tok.length = etok_pkg::clip16(etok_pkg::ClipBits'(off_q - start_q));
    run_tok.last   = 1'b0;

    own_tok.kind   = (cls == etok_pkg::CLS_END) ? etok_pkg::KIND_EOI
                                                : etok_pkg::single_kind(byte_q);
    own_tok.start  = etok_pkg::clip16(etok_pkg::ClipBits'(off_q));
    own_tok.length = (cls == etok_pkg::CLS_END) ? '0 : etok_pkg::FieldBits'(1);
    own_tok.last   = 1'b1;

    case (cls)
      etok_pkg::CLS_END: begin
        do_flush = has_run;
        do_own   = 1'b1;
      end
      etok_pkg::CLS_LETTER: begin
        do_flush = (mode_q == etok_pkg::MODE_DIGITS);
        do_own   = 1'b0;
      end
      etok_pkg::CLS_DIGIT: begin
        do_flush = (mode_q == etok_pkg::MODE_LETTERS);
        do_own   = 1'b0;
      end
      etok_pkg::CLS_SPACE: begin
        do_flush = has_run;
        do_own   = 1'b0;
      end
      default: begin
        do_flush = has_run;
        do_own   = 1'b1;
      end
    endcase
  end

  // token order: pending run first, then the byte's own token
  always_comb begin
    push_o.tok1 = own_tok;
    if (do_flush) begin
      push_o.push0     = fire;
      push_o.push1     = fire && do_own;
      push_o.tok0      = run_tok;
      push_o.tok0.last = !do_own;
    end else begin
      push_o.push0 = fire && do_own;
      push_o.push1 = 1'b0;
      push_o.tok0  = own_tok;
    end
  end

  // next run state
  always_comb begin
    off_adv  = (off_q == '1) ? off_q : off_q + OFFSET_BITS'(1);
    base_kp  = (mode_q == etok_pkg::MODE_LETTERS) ? kp_q : 3'd0;
    base_kf  = (mode_q == etok_pkg::MODE_LETTERS) ? kf_q : 1'b0;
    kw_match = (base_kp < 3'(etok_pkg::KwLen)) &&
               (byte_q == etok_pkg::kw_char(base_kp[1:0]));
    mode_d   = etok_pkg::MODE_NONE;
    off_d    = off_adv;
    start_d  = start_q;
    kp_d     = 3'd0;
    kf_d     = 1'b0;
    case (cls)
      etok_pkg::CLS_END: begin
        off_d   = '0;
        start_d = '0;
      end
      etok_pkg::CLS_LETTER: begin
        mode_d  = etok_pkg::MODE_LETTERS;
        start_d = (mode_q == etok_pkg::MODE_LETTERS) ? start_q : off_q;
        if (base_kf) begin
          kp_d = base_kp;
          kf_d = 1'b1;
        end else if (kw_match) begin
          kp_d = base_kp + 3'd1;
        end else begin
          kp_d = base_kp;
          kf_d = 1'b1;
        end
      end
      etok_pkg::CLS_DIGIT: begin
        mode_d  = etok_pkg::MODE_DIGITS;
        start_d = (mode_q == etok_pkg::MODE_DIGITS) ? start_q : off_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= etok_pkg::MODE_NONE;
      off_q   <= '0;
      start_q <= '0;
      kp_q    <= 3'd0;
      kf_q    <= 1'b0;
    end else if (fire) begin
      mode_q  <= mode_d;
      off_q   <= off_d;
      start_q <= start_d;
      kp_q    <= kp_d;
      kf_q    <= kf_d;
    end
  end

`ifndef SYNTHESIS
  // end of buffer restarts the offset and drops any run
  a_eoi_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && cls == etok_pkg::CLS_END |=> off_q == '0 && mode_q == etok_pkg::MODE_NONE)
    else $error("offset not restarted after end of buffer");
  // a pending run never starts beyond the current offset
  a_start_le_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != etok_pkg::MODE_NONE |-> start_q <= off_q)
    else $error("run start past current offset");
  // keyword match count stays within the keyword
  a_kp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kp_q <= 3'(etok_pkg::KwLen))
    else $error("keyword progress out of range");
`endif

endmodule

// ===== design/etok_fifo.sv =====
// Four-entry result queue: takes up to two tokens a cycle, gives one.
// Depends on etok_pkg.
module etok_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  etok_pkg::push_t  push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output etok_pkg::token_t out_tok_o
);

  etok_pkg::token_t                mem_q [etok_pkg::FifoDepth];
  logic [etok_pkg::PtrBits-1:0]    wr_q, rd_q, wr1;
  logic [etok_pkg::CntBits-1:0]    cnt_q, n_push;
  logic                            pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_tok_o   = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (cnt_q <= etok_pkg::CntBits'(etok_pkg::FifoDepth - 2));
  assign wr1         = wr_q + etok_pkg::PtrBits'(1);
  assign n_push      = etok_pkg::CntBits'(push_i.push0) + etok_pkg::CntBits'(push_i.push1);

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_q] <= push_i.tok0;
    end
    if (push_i.push1) begin
      mem_q[wr1] <= push_i.tok1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + etok_pkg::PtrBits'(n_push);
      rd_q  <= rd_q + etok_pkg::PtrBits'(pop);
      cnt_q <= cnt_q + n_push - etok_pkg::CntBits'(pop);
    end
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push0 |-> cnt_q <= etok_pkg::CntBits'(etok_pkg::FifoDepth - 2))
    else $error("push without room");
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push1 |-> push_i.push0)
    else $error("second token pushed without first");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= etok_pkg::CntBits'(etok_pkg::FifoDepth))
    else $error("queue overflow");
`endif

endmodule

// ===== design/expression_tokenizer_core.sv =====
// Expression tokenizer top level: byte register and run logic feeding a
// small result queue. Depends on etok_pkg, etok_if, etok_step, etok_fifo.
//
// Usage:
//   in_ch carries one text byte per item (char_in); a zero byte ends the
//   buffer. out_ch carries tokens: kind, start offset, length and
//   last_of_run, set on the final token caused by a byte.
//   A byte gives zero, one or two tokens. Whitespace and bytes inside a run
//   give none until the run ends.
//   Path: a byte is held in the byte register and its tokens are written
//   into the result queue, from which they are offered.
//   Throughput: one byte per cycle while the receiver takes one token per
//   cycle and the result queue has room; a byte that gives two tokens puts
//   both into the four-entry result queue, which gives one token at a time.
//   Receiver stall: tokens wait in the queue; once it holds more than two,
//   the held byte waits and in_ch.ready drops. Nothing is lost.
//   Reset: asynchronous, active low; clears the queue, the run state and
//   the offset. No clearing pass; a byte can be accepted as soon as reset
//   is released.
//   OFFSET_BITS sets the offset counter width; offsets saturate at its
//   maximum and reported values are clipped to 16 bits.
module expression_tokenizer_core #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  etok_in_if.sink      in_ch,
  etok_out_if.source   out_ch
);

  etok_pkg::push_t  push;
  etok_pkg::token_t out_tok;
  logic             room;

  etok_step #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .char_i     (in_ch.char_in),
    .room_i     (room),
    .push_o     (push)
  );

  etok_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_tok_o   (out_tok)
  );

  // token fields onto the output channel
  assign out_ch.token_kind   = out_tok.kind;
  assign out_ch.token_start  = out_tok.start;
  assign out_ch.token_length = out_tok.length;
  assign out_ch.last_of_run  = out_tok.last;

endmodule
